// ===== sv/gwm_pkg.sv =====
// Package for the glob wildcard matcher: character codes, action codes and
// the structs passed between the top level and the matcher cells.
// No dependencies.
package gwm_pkg;

	localparam int unsigned MAX_PATTERN_CHARS_DEF = 32;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned ACT_W = 2;

	localparam logic [CHAR_W-1:0] STAR_CHAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] QMARK_CHAR = 8'h3F;

	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CHAR   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_END    = 2'd3;

	// broadcast to every cell
	typedef struct packed {
		logic              restart;
		logic              consume;
		logic              wr;
		logic [CHAR_W-1:0] ch;
	} cell_ctl_t;

	// from a cell to its right neighbour
	typedef struct packed {
		logic m;   // literal or '?' step into the next position
		logic cl;  // star closure into the next position
	} link_t;

	typedef struct packed {
		logic accept; // active and at the end of the pattern
		logic star;   // holds a stored '*'
	} cell_stat_t;

endpackage

// ===== sv/gwm_in_if.sv =====
// Input channel of the glob wildcard matcher: action and character.
// Depends on gwm_pkg.
interface gwm_in_if;
	import gwm_pkg::*;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [CHAR_W-1:0] char_value;

	modport source (output valid, output action, output char_value, input ready);
	modport sink   (input valid, input action, input char_value, output ready);

endinterface

// ===== sv/gwm_out_if.sv =====
// Result channel of the glob wildcard matcher: match and overflow flags.
// No dependencies.
interface gwm_out_if;

	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink   (input valid, input matched, input pattern_overflow, output ready);

endinterface

// ===== sv/gwm_cell.sv =====
// One matcher cell: a stored pattern character and the active bit of its
// position. Depends on gwm_pkg.
module gwm_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned LEN_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gwm_pkg::cell_ctl_t ctl,
	input  logic [LEN_W-1:0]   clen,
	input  logic               rst_act,
	input  gwm_pkg::link_t     lin,
	output gwm_pkg::link_t     lout,
	output gwm_pkg::cell_stat_t stat
);
	import gwm_pkg::*;

	localparam logic [LEN_W-1:0] POS = LEN_W'(IDX);
	localparam logic RST_VAL = (IDX == 0);

	logic [CHAR_W-1:0] ch_q;
	logic              act_q;
	logic              valid;
	logic              is_star;
	logic              lit_ok;
	logic              pre;
	logic              nxt;

	assign valid   = POS < clen;
	assign is_star = valid && (ch_q == STAR_CHAR);
	assign lit_ok  = valid && !is_star && ((ch_q == QMARK_CHAR) || (ch_q == ctl.ch));

	// star runs are collapsed at load, so closure reaches one cell only
	assign pre     = (act_q && is_star) || lin.m;
	assign nxt     = pre || lin.cl;
	assign lout.m  = act_q && lit_ok;
	assign lout.cl = is_star && pre;

	assign stat.accept = act_q && !valid;
	assign stat.star   = is_star;

	always_ff @(posedge clk) begin
		if (ctl.wr && (clen == POS)) begin
			ch_q <= ctl.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= RST_VAL;
		end else if (ctl.restart) begin
			act_q <= rst_act;
		end else if (ctl.consume) begin
			act_q <= nxt;
		end
	end

endmodule

// ===== sv/glob_wildcard_matcher.sv =====
// Glob wildcard matcher top level: pattern loader, row of matcher cells, result register.
// Latency: a result is registered and shown the cycle after its end-of-string transaction.
// Throughput: one transaction per cycle while the result register is empty or being read.
// Reset: empty pattern, overflow flag clear, match restarted, result register empty.
// Depends on gwm_pkg, gwm_in_if, gwm_out_if and gwm_cell.
module glob_wildcard_matcher #(
	parameter int unsigned MAX_PATTERN_CHARS = gwm_pkg::MAX_PATTERN_CHARS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gwm_in_if.sink     item,
	gwm_out_if.source  result
);
	import gwm_pkg::*;

	localparam int unsigned N     = MAX_PATTERN_CHARS;
	localparam int unsigned LEN_W = $clog2(N + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(N);

	logic [LEN_W-1:0] rawlen_q;
	logic [LEN_W-1:0] clen_q;
	logic             last_star_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic             matched_q;
	logic             out_ovf_q;

	logic             acc;
	logic             room;
	logic             c_star;
	logic             star0_next;
	cell_ctl_t        ctl;
	logic [N:0]       rst_vec;
	logic [N:0]       accept_vec;
	link_t            links [0:N];
	link_t            link_tail;
	cell_stat_t       stat [0:N];

	assign item.ready = !out_valid_q || result.ready;
	assign acc        = item.valid && item.ready;
	assign room       = rawlen_q < LEN_MAX;
	assign c_star     = item.char_value == STAR_CHAR;

	assign ctl.consume = acc && (item.action == ACT_CHAR);
	assign ctl.restart = acc && (item.action != ACT_CHAR);
	// a star right after a star is counted but not stored
	assign ctl.wr      = acc && (item.action == ACT_APPEND) && room && !(c_star && last_star_q);
	assign ctl.ch      = item.char_value;

	always_comb begin
		if (item.action == ACT_CLEAR) begin
			star0_next = 1'b0;
		end else if (ctl.wr && (clen_q == '0)) begin
			star0_next = c_star;
		end else begin
			star0_next = stat[0].star;
		end
	end

	assign links[0] = '0;

	genvar i;
	generate
		for (i = 0; i <= N; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign rst_vec[i] = 1'b1;
			end else if (i == 1) begin : g_second
				assign rst_vec[i] = star0_next;
			end else begin : g_rest
				assign rst_vec[i] = 1'b0;
			end

			assign accept_vec[i] = stat[i].accept;

			if (i == N) begin : g_last
				gwm_cell #(.IDX(i), .LEN_W(LEN_W)) u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.clen    (clen_q),
					.rst_act (rst_vec[i]),
					.lin     (links[i]),
					.lout    (link_tail),
					.stat    (stat[i])
				);
			end else begin : g_mid
				gwm_cell #(.IDX(i), .LEN_W(LEN_W)) u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.clen    (clen_q),
					.rst_act (rst_vec[i]),
					.lin     (links[i]),
					.lout    (links[i+1]),
					.stat    (stat[i])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rawlen_q    <= '0;
			clen_q      <= '0;
			last_star_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (acc && (item.action == ACT_CLEAR)) begin
			rawlen_q    <= '0;
			clen_q      <= '0;
			last_star_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (acc && (item.action == ACT_APPEND)) begin
			if (room) begin
				rawlen_q    <= rawlen_q + 1'b1;
				last_star_q <= c_star;
				if (ctl.wr) begin
					clen_q <= clen_q + 1'b1;
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && (item.action == ACT_END)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (item.action == ACT_END)) begin
			matched_q <= |accept_vec;
			out_ovf_q <= ovf_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.matched          = matched_q;
	assign result.pattern_overflow = out_ovf_q;

	// a new result comes only from an end-of-string transaction
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(acc && (item.action == ACT_END)))
		else $error("result without end-of-string transaction");

	a_len_order: assert property (@(posedge clk) disable iff (!arst_n)
		(clen_q <= rawlen_q) && (rawlen_q <= LEN_MAX))
		else $error("stored length exceeds loaded length");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (rawlen_q == LEN_MAX))
		else $error("overflow flagged with room left");

	// only the cell at the pattern end can accept
	a_one_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(accept_vec))
		else $error("more than one accepting cell");

	a_tail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!(link_tail.m || link_tail.cl))
		else $error("activity beyond the last cell");

endmodule
